// ===== design/tcphb_pkg.sv =====
// Shared types and constants for the TCP/IPv4/Ethernet header builder.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tcphb_pkg;

  localparam int unsigned MaxPayload = 1460;
  localparam int unsigned CountW     = 11;
  localparam int unsigned HdrWords   = 27;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned AccW       = 20;
  localparam int unsigned CfgDataW   = 48;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [IdxW-1:0]   LastIdx    = IdxW'(HdrWords - 1);
  localparam logic [CountW-1:0] MaxPayloadC = CountW'(MaxPayload);

  // Fixed header field values.
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [15:0] IpVerIhlTos   = 16'h4500;
  localparam logic [7:0]  ProtoTcp      = 8'h06;
  localparam logic [15:0] IpHdrBytes    = 16'd40;
  localparam logic [15:0] TcpHdrBytes   = 16'd20;
  localparam logic [10:0] FrameHdrBytes = 11'd54;
  localparam logic [15:0] TcpOffsetWord = 16'h5000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEST_MAC     = 3'd0,
    REG_SOURCE_MAC   = 3'd1,
    REG_SOURCE_IP    = 3'd2,
    REG_DEST_IP      = 3'd3,
    REG_SOURCE_PORT  = 3'd4,
    REG_DEST_PORT    = 3'd5,
    REG_TIME_TO_LIVE = 3'd6,
    REG_WINDOW_SIZE  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  time_to_live;
    logic [15:0] window_size;
  } cfg_t;

  // One finished segment, as handed from the front to the back.
  typedef struct packed {
    logic [15:0]       psum;
    logic [CountW-1:0] byte_count;
    logic              overflow;
    logic [31:0]       seq_number;
    logic [31:0]       ack_number;
    logic [4:0]        tcp_flags;
  } seg_desc_t;

  // One's-complement add of two 16-bit words with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ===== design/tcphb_front.sv =====
// Front part: accepts payload items, keeps the running payload sum and count,
// and hands a segment descriptor to the queue on the last item. Uses tcphb_pkg.
`timescale 1ns / 1ps

module tcphb_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            payload_byte_i,
  input  logic                  byte_valid_i,
  input  logic                  end_of_segment_i,
  input  logic [31:0]           seq_number_i,
  input  logic [31:0]           ack_number_i,
  input  logic [4:0]            tcp_flags_i,
  output logic                  desc_push_o,
  output tcphb_pkg::seg_desc_t  desc_o
);

  logic [15:0]                  sum_q, sum_d;
  logic [tcphb_pkg::CountW-1:0] count_q, count_d;
  logic                         odd_q, odd_d;
  logic [7:0]                   held_q, held_d;
  logic                         ovf_q, ovf_d;

  logic        take, drop, pair, start, odd_next, do_add;
  logic [15:0] add_word, added, psum_final;
  logic [tcphb_pkg::CountW-1:0] count_next;

  always_comb begin
    take       = byte_valid_i && (count_q < tcphb_pkg::MaxPayloadC);
    drop       = byte_valid_i && !take;
    pair       = take && odd_q;
    start      = take && !odd_q;
    odd_next   = start || (odd_q && !take);
    count_next = count_q + {{(tcphb_pkg::CountW-1){1'b0}}, take};
    // A completed pair adds the word itself; a lone trailing byte is added
    // with a zero low half when the segment closes.
    if (pair) begin
      add_word = {held_q, payload_byte_i};
    end else if (start) begin
      add_word = {payload_byte_i, 8'h00};
    end else begin
      add_word = {held_q, 8'h00};
    end
    added      = tcphb_pkg::oc_add(sum_q, add_word);
    do_add     = pair || (end_of_segment_i && odd_next);
    psum_final = do_add ? added : sum_q;

    sum_d   = sum_q;
    count_d = count_q;
    odd_d   = odd_q;
    held_d  = held_q;
    ovf_d   = ovf_q;
    if (accept_i) begin
      if (end_of_segment_i) begin
        sum_d   = '0;
        count_d = '0;
        odd_d   = 1'b0;
        held_d  = '0;
        ovf_d   = 1'b0;
      end else begin
        sum_d   = pair ? added : sum_q;
        count_d = count_next;
        odd_d   = odd_next;
        held_d  = start ? payload_byte_i : held_q;
        ovf_d   = ovf_q | drop;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      odd_q   <= 1'b0;
      held_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      odd_q   <= odd_d;
      held_q  <= held_d;
      ovf_q   <= ovf_d;
    end
  end

  assign desc_push_o       = accept_i && end_of_segment_i;
  assign desc_o.psum       = psum_final;
  assign desc_o.byte_count = count_next;
  assign desc_o.overflow   = ovf_q | drop;
  assign desc_o.seq_number = seq_number_i;
  assign desc_o.ack_number = ack_number_i;
  assign desc_o.tcp_flags  = tcp_flags_i;

endmodule

// ===== design/tcphb_queue.sv =====
// Two-entry queue of segment descriptors between the front and the back.
// Uses tcphb_pkg for the descriptor type.
`timescale 1ns / 1ps

module tcphb_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tcphb_pkg::seg_desc_t  data_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic                  valid_o,
  output tcphb_pkg::seg_desc_t  data_o
);

  tcphb_pkg::seg_desc_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== design/tcphb_back.sv =====
// Back part: takes one segment descriptor at a time, works out both checksums
// in steps after the descriptor is loaded and presents the 27 header words. Uses tcphb_pkg.
`timescale 1ns / 1ps

module tcphb_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tcphb_pkg::cfg_t                  cfg_i,
  input  logic                             desc_valid_i,
  input  tcphb_pkg::seg_desc_t             desc_i,
  output logic                             desc_pop_o,
  input  logic                             pop_i,
  output logic                             empty_o,
  output logic [15:0]                      header_word_o,
  output logic [tcphb_pkg::IdxW-1:0]       word_index_o,
  output logic [tcphb_pkg::CountW-1:0]     frame_length_o,
  output logic                             payload_overflow_o,
  output logic                             last_word_o
);

  localparam int unsigned AccW = tcphb_pkg::AccW;

  tcphb_pkg::seg_desc_t         desc_q;
  logic                         busy_q;
  logic [tcphb_pkg::IdxW-1:0]   idx_q;
  logic [2:0]                   step_q;
  logic [AccW-1:0]              ip_acc_q, tcp_acc_q;

  logic load, advance, last;
  logic [15:0] len_ip, len_tcp;

  function automatic logic [AccW-1:0] add3(input logic [AccW-1:0] a, input logic [15:0] b,
                                           input logic [15:0] c, input logic [15:0] d);
    return a + {{(AccW-16){1'b0}}, b} + {{(AccW-16){1'b0}}, c}
             + {{(AccW-16){1'b0}}, d};
  endfunction

  function automatic logic [AccW-1:0] fold(input logic [AccW-1:0] a);
    return {{(AccW-16){1'b0}}, a[15:0]} + {16'd0, a[AccW-1:16]};
  endfunction

  assign last      = (idx_q == tcphb_pkg::LastIdx);
  assign advance   = busy_q && pop_i;
  assign load      = desc_valid_i && (!busy_q || (advance && last));
  assign desc_pop_o = load;

  assign len_ip  = tcphb_pkg::IpHdrBytes + {5'd0, desc_i.byte_count};
  assign len_tcp = tcphb_pkg::TcpHdrBytes + {5'd0, desc_i.byte_count};

  always_ff @(posedge clk_i) begin
    if (load) begin
      desc_q <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= '0;
      step_q    <= 3'd0;
      ip_acc_q  <= '0;
      tcp_acc_q <= '0;
    end else begin
      if (load) begin
        busy_q    <= 1'b1;
        idx_q     <= '0;
        step_q    <= 3'd1;
        ip_acc_q  <= add3('0, tcphb_pkg::IpVerIhlTos, len_ip,
                          {cfg_i.time_to_live, tcphb_pkg::ProtoTcp});
        tcp_acc_q <= add3('0, {8'd0, tcphb_pkg::ProtoTcp}, len_tcp, desc_i.psum);
      end else begin
        if (advance) begin
          if (last) begin
            busy_q <= 1'b0;
          end else begin
            idx_q <= idx_q + tcphb_pkg::IdxW'(1);
          end
        end
        // The checksum steps finish well before word 12 can be reached.
        case (step_q)
          3'd1: begin
            ip_acc_q  <= add3(ip_acc_q, cfg_i.source_ip[31:16], cfg_i.source_ip[15:0], 16'd0);
            tcp_acc_q <= add3(tcp_acc_q, cfg_i.source_ip[31:16], cfg_i.source_ip[15:0],
                              cfg_i.source_port);
            step_q    <= 3'd2;
          end
          3'd2: begin
            ip_acc_q  <= add3(ip_acc_q, cfg_i.dest_ip[31:16], cfg_i.dest_ip[15:0], 16'd0);
            tcp_acc_q <= add3(tcp_acc_q, cfg_i.dest_ip[31:16], cfg_i.dest_ip[15:0],
                              cfg_i.dest_port);
            step_q    <= 3'd3;
          end
          3'd3: begin
            ip_acc_q  <= fold(ip_acc_q);
            tcp_acc_q <= add3(tcp_acc_q, desc_q.seq_number[31:16], desc_q.seq_number[15:0],
                              desc_q.ack_number[31:16]);
            step_q    <= 3'd4;
          end
          3'd4: begin
            ip_acc_q  <= fold(ip_acc_q);
            tcp_acc_q <= add3(tcp_acc_q, desc_q.ack_number[15:0],
                              tcphb_pkg::TcpOffsetWord | {11'd0, desc_q.tcp_flags},
                              cfg_i.window_size);
            step_q    <= 3'd5;
          end
          3'd5: begin
            tcp_acc_q <= fold(tcp_acc_q);
            step_q    <= 3'd6;
          end
          3'd6: begin
            tcp_acc_q <= fold(tcp_acc_q);
            step_q    <= 3'd0;
          end
          default: begin
            step_q <= 3'd0;
          end
        endcase
      end
    end
  end

  always_comb begin
    case (idx_q)
      5'd0:  header_word_o = cfg_i.dest_mac[47:32];
      5'd1:  header_word_o = cfg_i.dest_mac[31:16];
      5'd2:  header_word_o = cfg_i.dest_mac[15:0];
      5'd3:  header_word_o = cfg_i.source_mac[47:32];
      5'd4:  header_word_o = cfg_i.source_mac[31:16];
      5'd5:  header_word_o = cfg_i.source_mac[15:0];
      5'd6:  header_word_o = tcphb_pkg::EtherTypeIpv4;
      5'd7:  header_word_o = tcphb_pkg::IpVerIhlTos;
      5'd8:  header_word_o = tcphb_pkg::IpHdrBytes + {5'd0, desc_q.byte_count};
      5'd11: header_word_o = {cfg_i.time_to_live, tcphb_pkg::ProtoTcp};
      5'd12: header_word_o = ~ip_acc_q[15:0];
      5'd13: header_word_o = cfg_i.source_ip[31:16];
      5'd14: header_word_o = cfg_i.source_ip[15:0];
      5'd15: header_word_o = cfg_i.dest_ip[31:16];
      5'd16: header_word_o = cfg_i.dest_ip[15:0];
      5'd17: header_word_o = cfg_i.source_port;
      5'd18: header_word_o = cfg_i.dest_port;
      5'd19: header_word_o = desc_q.seq_number[31:16];
      5'd20: header_word_o = desc_q.seq_number[15:0];
      5'd21: header_word_o = desc_q.ack_number[31:16];
      5'd22: header_word_o = desc_q.ack_number[15:0];
      5'd23: header_word_o = tcphb_pkg::TcpOffsetWord | {11'd0, desc_q.tcp_flags};
      5'd24: header_word_o = cfg_i.window_size;
      5'd25: header_word_o = ~tcp_acc_q[15:0];
      default: header_word_o = 16'd0;
    endcase
  end

  assign empty_o            = !busy_q;
  assign word_index_o       = idx_q;
  assign frame_length_o     = tcphb_pkg::FrameHdrBytes + desc_q.byte_count;
  assign payload_overflow_o = desc_q.overflow;
  assign last_word_o        = last;

endmodule

// ===== design/tcp_ipv4_ethernet_header_builder.sv =====
// Top level of the TCP/IPv4/Ethernet header builder: configuration registers
// and the front, queue and back parts. Uses tcphb_pkg and the tcphb modules.
`timescale 1ns / 1ps

// Channel    | Direction | Handshake             | Payload
// payload in | input     | push / full           | payload_byte, byte_valid, end_of_segment,
//            |           |                       | seq_number, ack_number, tcp_flags
// header out | output    | empty / pop           | header_word, word_index, frame_length,
//            |           |                       | payload_overflow, last_word
// config     | input     | cfg_we_i (no wait)    | cfg_index_i, cfg_data_i
//
// Payload items are taken one per cycle while full is low. A segment's header is 27 words,
// and the back part presents one word per cycle while pop is held; when the next
// descriptor is waiting, its first word follows the last word with no gap.
// The checksums are accumulated after a segment enters the back part, overlapped
// with its first header words. A two-entry descriptor queue lets payload for the
// next segments keep arriving while a header drains; full is raised only when two
// closed segments are waiting. Reset clears all accumulation and control state and
// loads the register defaults; no clearing pass is needed.

module tcp_ipv4_ethernet_header_builder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Payload input channel.
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        payload_byte_i,
  input  logic                              byte_valid_i,
  input  logic                              end_of_segment_i,
  input  logic [31:0]                       seq_number_i,
  input  logic [31:0]                       ack_number_i,
  input  logic [4:0]                        tcp_flags_i,
  // Header word output channel.
  output logic                              empty,
  input  logic                              pop,
  output logic [15:0]                       header_word_o,
  output logic [tcphb_pkg::IdxW-1:0]        word_index_o,
  output logic [tcphb_pkg::CountW-1:0]      frame_length_o,
  output logic                              payload_overflow_o,
  output logic                              last_word_o,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [tcphb_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [tcphb_pkg::CfgDataW-1:0]    cfg_data_i
);

  tcphb_pkg::cfg_t      cfg_q;
  tcphb_pkg::seg_desc_t front_desc, queue_desc;
  logic                 accept, desc_push, desc_valid, desc_pop;

  // Configuration registers. The user must write them only while the block is idle; the
  // block does not enforce it. The back part reads them directly while building a header.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_mac     <= 48'd0;
      cfg_q.source_mac   <= 48'd0;
      cfg_q.source_ip    <= 32'd0;
      cfg_q.dest_ip      <= 32'd0;
      cfg_q.source_port  <= 16'd0;
      cfg_q.dest_port    <= 16'd80;
      cfg_q.time_to_live <= 8'd64;
      cfg_q.window_size  <= 16'hffff;
    end else if (cfg_we_i) begin
      case (tcphb_pkg::cfg_reg_e'(cfg_index_i))
        tcphb_pkg::REG_DEST_MAC:     cfg_q.dest_mac     <= cfg_data_i;
        tcphb_pkg::REG_SOURCE_MAC:   cfg_q.source_mac   <= cfg_data_i;
        tcphb_pkg::REG_SOURCE_IP:    cfg_q.source_ip    <= cfg_data_i[31:0];
        tcphb_pkg::REG_DEST_IP:      cfg_q.dest_ip      <= cfg_data_i[31:0];
        tcphb_pkg::REG_SOURCE_PORT:  cfg_q.source_port  <= cfg_data_i[15:0];
        tcphb_pkg::REG_DEST_PORT:    cfg_q.dest_port    <= cfg_data_i[15:0];
        tcphb_pkg::REG_TIME_TO_LIVE: cfg_q.time_to_live <= cfg_data_i[7:0];
        tcphb_pkg::REG_WINDOW_SIZE:  cfg_q.window_size  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // A request is taken whenever the descriptor queue has room.
  assign accept = push && !full;

  tcphb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .payload_byte_i   (payload_byte_i),
    .byte_valid_i     (byte_valid_i),
    .end_of_segment_i (end_of_segment_i),
    .seq_number_i     (seq_number_i),
    .ack_number_i     (ack_number_i),
    .tcp_flags_i      (tcp_flags_i),
    .desc_push_o      (desc_push),
    .desc_o           (front_desc)
  );

  tcphb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .data_i  (front_desc),
    .pop_i   (desc_pop),
    .full_o  (full),
    .valid_o (desc_valid),
    .data_o  (queue_desc)
  );

  tcphb_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .desc_valid_i       (desc_valid),
    .desc_i             (queue_desc),
    .desc_pop_o         (desc_pop),
    .pop_i              (pop),
    .empty_o            (empty),
    .header_word_o      (header_word_o),
    .word_index_o       (word_index_o),
    .frame_length_o     (frame_length_o),
    .payload_overflow_o (payload_overflow_o),
    .last_word_o        (last_word_o)
  );

endmodule

// ===== design/tcphb_checker.sv =====
// Port-level checks for the header builder output channel, and the bind that
// attaches them to the top level. Uses tcphb_pkg.
`timescale 1ns / 1ps

module tcphb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          empty,
  input logic                          pop,
  input logic [15:0]                   header_word_i,
  input logic [tcphb_pkg::IdxW-1:0]    word_index_i,
  input logic [tcphb_pkg::CountW-1:0]  frame_length_i,
  input logic                          last_word_i
);

  // The last-word flag marks exactly the final header position.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_word_i == (word_index_i == tcphb_pkg::LastIdx)))
    else $error("last_word does not match word_index");

  // Within a header the words follow in order with no gap.
  a_next_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_word_i) |=>
      (!empty && word_index_i == $past(word_index_i) + tcphb_pkg::IdxW'(1)
       && $stable(frame_length_i)))
    else $error("header word sequence broken");

  // After the last word, a following header starts at position zero.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && last_word_i) |=> (empty || word_index_i == '0))
    else $error("new header does not start at word zero");

  // A word that is not taken stays on the ports.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(header_word_i) && $stable(word_index_i)))
    else $error("stalled header word changed");

endmodule

bind tcp_ipv4_ethernet_header_builder tcphb_checker u_tcphb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .header_word_i  (header_word_o),
  .word_index_i   (word_index_o),
  .frame_length_i (frame_length_o),
  .last_word_i    (last_word_o)
);
